FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Every macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define MLPD_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define MLPD_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define MLPD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: sv/mlpd_pkg.sv
`default_nettype none

package mlpd_pkg;

  localparam int NumChannelsDef = 128;
  localparam int ChanW          = 7;
  localparam int ByteW          = 8;
  localparam int ChanSpace      = 1 << ChanW;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  // Per-channel reassembly state held in the state memory.
  typedef struct packed {
    logic [ByteW-1:0] fill;
    logic [ByteW-1:0] exp_len;
  } entry_t;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] offset;
    logic             first;
    logic             last;
    logic             bad;
  } result_t;

  // Only channel numbers that fit the channel field can ever address the memory.
  function automatic int mem_depth(input int num_channels);
    return (num_channels < ChanSpace) ? num_channels : ChanSpace;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mlpd_state_mem.sv
`default_nettype none

module mlpd_state_mem #(
  parameter int DEPTH = 128,
  parameter int IDX_W = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  rd_en,
  input  wire logic [IDX_W-1:0]      rd_addr,
  output mlpd_pkg::entry_t           rd_data,
  input  wire logic                  wr_en,
  input  wire logic [IDX_W-1:0]      wr_addr,
  input  wire mlpd_pkg::entry_t      wr_data
);

  mlpd_pkg::entry_t mem [DEPTH];
  mlpd_pkg::entry_t mem_q_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // An entry never written reads as the reset state: awaiting a length byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? mem_q_r : '0;

endmodule

`default_nettype wire

FILE: sv/mlpd_update.sv
`default_nettype none

module mlpd_update (
  input  wire mlpd_pkg::op_t                op,
  input  wire logic [mlpd_pkg::ChanW-1:0]   chan,
  input  wire logic [mlpd_pkg::ByteW-1:0]   data_byte,
  input  wire mlpd_pkg::entry_t             cur,
  output mlpd_pkg::entry_t                  nxt,
  output mlpd_pkg::result_t                 res,
  output logic                              res_vld
);

  logic [mlpd_pkg::ByteW:0] fill_inc;

  assign fill_inc = {1'b0, cur.fill} + {{mlpd_pkg::ByteW{1'b0}}, 1'b1};

  always_comb begin
    nxt        = cur;
    res        = '0;
    res.chan   = chan;
    res.data   = data_byte;
    res.offset = cur.fill;
    res_vld    = 1'b0;
    case (op)
      mlpd_pkg::OP_CLOSE: begin
        nxt = '0;
      end
      mlpd_pkg::OP_DATA: begin
        res_vld = 1'b1;
        if (cur.fill == '0) begin
          if (data_byte == '0) begin
            // A zero length would never complete, so it is flagged and dropped.
            res.bad = 1'b1;
          end else if (data_byte == {{(mlpd_pkg::ByteW-1){1'b0}}, 1'b1}) begin
            res.first   = 1'b1;
            res.last    = 1'b1;
            nxt.exp_len = '0;
          end else begin
            res.first   = 1'b1;
            nxt.exp_len = data_byte;
            nxt.fill    = {{(mlpd_pkg::ByteW-1){1'b0}}, 1'b1};
          end
        end else if (fill_inc >= {1'b0, cur.exp_len}) begin
          res.last = 1'b1;
          nxt      = '0;
        end else begin
          nxt.fill = fill_inc[mlpd_pkg::ByteW-1:0];
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/multichannel_length_prefix_deframer_core.sv
// Pipeline: the input register (s1) feeds the state update, whose result is registered for output.
// Throughput: one item per cycle while the output does not stall; the state memory is read at
// input and written as s1 advances, with the last write forwarded so back-to-back bytes on a channel work.
// Reset: synchronous active-low rst_n clears the pipeline and the per-channel valid
// bits, so every channel starts out awaiting a length byte with no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module multichannel_length_prefix_deframer_core #(
  parameter int NUM_CHANNELS = mlpd_pkg::NumChannelsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic [mlpd_pkg::ChanW-1:0]    in_channel,
  input  wire logic [mlpd_pkg::ByteW-1:0]    in_data_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mlpd_pkg::ChanW-1:0]         out_channel,
  output logic [mlpd_pkg::ByteW-1:0]         out_byte,
  output logic [mlpd_pkg::ByteW-1:0]         out_byte_offset,
  output logic                               out_first_of_packet,
  output logic                               out_last_of_packet,
  output logic                               out_bad_length
);

  localparam int DEPTH = mlpd_pkg::mem_depth(NUM_CHANNELS);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                         accept;
  logic                         in_range;
  logic                         s1_adv;

  logic                         s1_valid_r, s1_valid_nxt;
  mlpd_pkg::op_t                s1_op_r;
  logic [mlpd_pkg::ChanW-1:0]   s1_chan_r;
  logic [mlpd_pkg::ByteW-1:0]   s1_byte_r;
  logic [IDX_W-1:0]             s1_idx;

  mlpd_pkg::entry_t             rd_data;
  mlpd_pkg::entry_t             cur;
  mlpd_pkg::entry_t             wr_data;
  logic                         wr_en;

  logic                         lw_valid_r;
  logic [IDX_W-1:0]             lw_idx_r;
  mlpd_pkg::entry_t             lw_data_r;

  mlpd_pkg::result_t            res;
  logic                         res_vld;
  logic                         out_valid_r, out_valid_nxt;
  mlpd_pkg::result_t            out_r;

  assign in_range = 32'(in_channel) < 32'(NUM_CHANNELS);
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign s1_idx   = s1_chan_r[IDX_W-1:0];
  assign wr_en    = s1_valid_r && s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = in_range;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= mlpd_pkg::op_t'(in_opcode);
      s1_chan_r <= in_channel;
      s1_byte_r <= in_data_byte;
    end
  end

  mlpd_state_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_channel[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_idx),
    .wr_data (wr_data)
  );

  // The read issued with this item missed the write made on the same edge.
  assign cur = (lw_valid_r && (lw_idx_r == s1_idx)) ? lw_data_r : rd_data;

  mlpd_update u_update (
    .op        (s1_op_r),
    .chan      (s1_chan_r),
    .data_byte (s1_byte_r),
    .cur       (cur),
    .nxt       (wr_data),
    .res       (res),
    .res_vld   (res_vld)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (wr_en) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_idx_r  <= s1_idx;
      lw_data_r <= wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_channel         = out_r.chan;
  assign out_byte            = out_r.data;
  assign out_byte_offset     = out_r.offset;
  assign out_first_of_packet = out_r.first;
  assign out_last_of_packet  = out_r.last;
  assign out_bad_length      = out_r.bad;

  `MLPD_ASSERT_IMPLY(a_bad_len_clean, out_valid_r && out_r.bad,
                     (out_r.data == '0) && (out_r.offset == '0) && !out_r.first && !out_r.last)
  `MLPD_ASSERT_IMPLY(a_first_at_zero, out_valid_r && out_r.first, out_r.offset == '0)
  `MLPD_ASSERT_NEXT(a_stall_holds_read, s1_valid_r && !s1_adv, $stable(rd_data))
  `MLPD_ASSERT_NEXT(a_fwd_tracks_write, wr_en,
                    lw_valid_r && (lw_data_r == $past(wr_data)))

endmodule

`default_nettype wire
